// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the dispense sequencer RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define SGDS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain condition checked at every rising clock edge outside reset.
`define SGDS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== rtl/core/sgds_pkg.sv =====
// Package for the sensor gated dispense sequencer: phase codes, register
// indexes, configuration and result structs, default parameter values.
`timescale 1ns / 1ps

package sgds_pkg;

  localparam int CAL_SAMPLES_DEF = 20;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int THR_W   = 10;
  localparam int COUNT_W = 8;
  localparam int TOWER_W = 3;
  localparam int SPEED_W = 8;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(500);

  localparam logic [CFG_IDX_W-1:0] CFG_THR_BACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FRONT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOWER     = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CAL   = 3'd1,
    PH_BACK  = 3'd2,
    PH_FWAIT = 3'd3,
    PH_FCOV  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [THR_W-1:0]   thr_back;
    logic [THR_W-1:0]   thr_front;
    logic [COUNT_W-1:0] init_count;
    logic [TOWER_W-1:0] tower_num;
  } cfg_t;

  typedef struct packed {
    logic [SPEED_W-1:0] back_drive;
    logic [SPEED_W-1:0] front_drive;
    logic               tower_power;
    logic [TOWER_W-1:0] tower_select;
    phase_t             phase;
    logic               done_res;
    logic [COUNT_W-1:0] remaining;
  } res_t;

endpackage

// ===== rtl/core/sgds_ctrl.sv =====
// Sequencer state and phase control for one tower.
// Depends on sgds_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgds_ctrl #(
  parameter int CAL_SAMPLES = sgds_pkg::CAL_SAMPLES_DEF,
  parameter int SAMPLE_BITS = sgds_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic                         kind,
  input  logic [SAMPLE_BITS-1:0]       back_sample,
  input  logic [SAMPLE_BITS-1:0]       front_sample,
  input  logic [sgds_pkg::SPEED_W-1:0] speed_back,
  input  logic [sgds_pkg::SPEED_W-1:0] speed_front,
  input  sgds_pkg::cfg_t               cfg,
  output sgds_pkg::res_t               res_nxt
);
  import sgds_pkg::*;

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int X_W   = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;
  localparam int P_W   = X_W + CNT_W;
  localparam logic [P_W-1:0]   C_P     = P_W'(CAL_SAMPLES);
  localparam logic [CNT_W-1:0] CAL_END = CNT_W'(CAL_SAMPLES);

  phase_t             phase_r, phase_nxt;
  logic               calibrated_r, calibrated_nxt;
  logic [CNT_W-1:0]   cal_cnt_r, cal_cnt_nxt;
  logic [SUM_W-1:0]   sum_back_r, sum_back_nxt;
  logic [SUM_W-1:0]   sum_front_r, sum_front_nxt;
  logic [SUM_W-1:0]   bl_back_r, bl_back_nxt;
  logic [SUM_W-1:0]   bl_front_r, bl_front_nxt;
  logic [SPEED_W-1:0] lspd_back_r, lspd_back_nxt;
  logic [SPEED_W-1:0] lspd_front_r, lspd_front_nxt;
  logic               bmo_r, bmo_nxt;
  logic [COUNT_W-1:0] tally_r, tally_nxt;
  logic               done;

  // Baselines are kept as sums: x <= floor(s/N) iff x*N <= s.
  logic [X_W-1:0]   x_back, x_front;
  logic [P_W-1:0]   p_back, p_back1, p_front, p_front1, s_back, s_front;
  logic             back_cov_le, back_cov_lt, front_cov_lt, front_uncov;
  logic [CNT_W-1:0] cal_inc;

  assign x_back   = X_W'(back_sample) + X_W'(cfg.thr_back);
  assign x_front  = X_W'(front_sample) + X_W'(cfg.thr_front);
  assign p_back   = P_W'(x_back) * C_P;
  assign p_front  = P_W'(x_front) * C_P;
  assign p_back1  = p_back + C_P;
  assign p_front1 = p_front + C_P;
  assign s_back   = P_W'(bl_back_r);
  assign s_front  = P_W'(bl_front_r);

  assign back_cov_le  = (p_back <= s_back);
  assign back_cov_lt  = (p_back1 <= s_back);
  assign front_cov_lt = (p_front1 <= s_front);
  assign front_uncov  = (p_front > s_front);
  assign cal_inc      = cal_cnt_r + CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (!kind) begin
        if (phase_r == PH_IDLE) begin
          phase_nxt = calibrated_r ? PH_BACK : PH_CAL;
        end
      end else begin
        case (phase_r)
          PH_CAL:   if (cal_inc >= CAL_END) phase_nxt = PH_BACK;
          PH_BACK:  if (back_cov_le) phase_nxt = PH_FWAIT;
          PH_FWAIT: if (front_cov_lt) phase_nxt = PH_FCOV;
          PH_FCOV:  if (front_uncov) phase_nxt = PH_IDLE;
          default:  phase_nxt = phase_r;
        endcase
      end
    end
  end

  always_comb begin
    calibrated_nxt = calibrated_r;
    cal_cnt_nxt    = cal_cnt_r;
    sum_back_nxt   = sum_back_r;
    sum_front_nxt  = sum_front_r;
    bl_back_nxt    = bl_back_r;
    bl_front_nxt   = bl_front_r;
    lspd_back_nxt  = lspd_back_r;
    lspd_front_nxt = lspd_front_r;
    bmo_nxt        = bmo_r;
    tally_nxt      = tally_r;
    done           = 1'b0;
    if (fire) begin
      if (!kind) begin
        if (phase_r == PH_IDLE) begin
          lspd_back_nxt  = speed_back;
          lspd_front_nxt = speed_front;
          if (!calibrated_r) begin
            cal_cnt_nxt   = '0;
            sum_back_nxt  = '0;
            sum_front_nxt = '0;
            bmo_nxt       = 1'b0;
          end else begin
            bmo_nxt = 1'b1;
          end
        end
      end else begin
        case (phase_r)
          PH_CAL: begin
            sum_back_nxt  = sum_back_r + SUM_W'(back_sample);
            sum_front_nxt = sum_front_r + SUM_W'(front_sample);
            cal_cnt_nxt   = cal_inc;
            if (cal_inc >= CAL_END) begin
              bl_back_nxt    = sum_back_nxt;
              bl_front_nxt   = sum_front_nxt;
              calibrated_nxt = 1'b1;
              cal_cnt_nxt    = '0;
              bmo_nxt        = 1'b1;
            end
          end
          PH_FWAIT: bmo_nxt = back_cov_lt;
          PH_FCOV: begin
            if (front_uncov) begin
              bmo_nxt = 1'b0;
              done    = 1'b1;
              if (tally_r != {COUNT_W{1'b1}}) tally_nxt = tally_r + COUNT_W'(1);
            end
          end
          default: bmo_nxt = bmo_r;
        endcase
      end
    end
  end

  always_comb begin
    res_nxt.back_drive   = bmo_nxt ? lspd_back_nxt : '0;
    res_nxt.front_drive  = (phase_nxt == PH_FWAIT || phase_nxt == PH_FCOV) ?
                           lspd_front_nxt : '0;
    res_nxt.tower_power  = (phase_nxt != PH_IDLE);
    res_nxt.tower_select = cfg.tower_num;
    res_nxt.phase        = phase_nxt;
    res_nxt.done_res     = done;
    res_nxt.remaining    = (cfg.init_count > tally_nxt) ? (cfg.init_count - tally_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      calibrated_r <= 1'b0;
      cal_cnt_r    <= '0;
      sum_back_r   <= '0;
      sum_front_r  <= '0;
      bl_back_r    <= '0;
      bl_front_r   <= '0;
      lspd_back_r  <= '0;
      lspd_front_r <= '0;
      bmo_r        <= 1'b0;
      tally_r      <= '0;
    end else begin
      phase_r      <= phase_nxt;
      calibrated_r <= calibrated_nxt;
      cal_cnt_r    <= cal_cnt_nxt;
      sum_back_r   <= sum_back_nxt;
      sum_front_r  <= sum_front_nxt;
      bl_back_r    <= bl_back_nxt;
      bl_front_r   <= bl_front_nxt;
      lspd_back_r  <= lspd_back_nxt;
      lspd_front_r <= lspd_front_nxt;
      bmo_r        <= bmo_nxt;
      tally_r      <= tally_nxt;
    end
  end

  `SGDS_ASSERT_IMPL(a_cal_only_uncal, phase_r == PH_CAL, !calibrated_r, "calibrating twice")
  `SGDS_ASSERT_IMPL(a_back_motor_run, phase_r == PH_BACK, calibrated_r && bmo_r, "back run bad")
  `SGDS_ASSERT_IMPL(a_idle_motor_off, phase_r == PH_IDLE, !bmo_r, "motor on while idle")
  `SGDS_ASSERT_IMPL(a_done_to_idle, res_nxt.done_res, phase_nxt == PH_IDLE, "done not idle")
  `SGDS_ASSERT(a_cal_cnt_range, cal_cnt_r < CAL_END, "calibration count overrun")

endmodule

// ===== rtl/core/sensor_gated_dispense_sequencer_top.sv =====
// Sensor gated dispense sequencer. Accepts one item (start command or sensor
// sample pair) per cycle while not stalled and returns one result per item
// through an input register, then the phase logic into the result register.
// Calibration averages CAL_SAMPLES sample pairs after the first start; baselines
// are held as sums and compared against sample plus threshold times CAL_SAMPLES.
// A stalled result holds both stages; the input stalls only while the result does.
// Depends on sgds_pkg, sgds_ctrl and assert_macros.svh.
`timescale 1ns / 1ps

module sensor_gated_dispense_sequencer_top #(
  parameter int CAL_SAMPLES = sgds_pkg::CAL_SAMPLES_DEF,
  parameter int SAMPLE_BITS = sgds_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sgds_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sgds_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [SAMPLE_BITS-1:0]         in_back_sample,
  input  logic [SAMPLE_BITS-1:0]         in_front_sample,
  input  logic [sgds_pkg::SPEED_W-1:0]   in_speed_back,
  input  logic [sgds_pkg::SPEED_W-1:0]   in_speed_front,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sgds_pkg::SPEED_W-1:0]   out_back_drive,
  output logic [sgds_pkg::SPEED_W-1:0]   out_front_drive,
  output logic                           out_tower_power,
  output logic [sgds_pkg::TOWER_W-1:0]   out_tower_select,
  output logic [2:0]                     out_phase,
  output logic                           out_done_res,
  output logic [sgds_pkg::COUNT_W-1:0]   out_remaining
);
  import sgds_pkg::*;

  cfg_t cfg_r;
  logic advance;

  logic                   s1_valid_r;
  logic                   s1_kind_r;
  logic [SAMPLE_BITS-1:0] s1_back_r, s1_front_r;
  logic [SPEED_W-1:0]     s1_spd_back_r, s1_spd_front_r;

  logic out_valid_r;
  res_t res_nxt, res_r;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr_back   <= THR_RESET;
      cfg_r.thr_front  <= THR_RESET;
      cfg_r.init_count <= '0;
      cfg_r.tower_num  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_THR_BACK:  cfg_r.thr_back   <= cfg_wdata[THR_W-1:0];
        CFG_THR_FRONT: cfg_r.thr_front  <= cfg_wdata[THR_W-1:0];
        CFG_INIT_CNT:  cfg_r.init_count <= cfg_wdata[COUNT_W-1:0];
        CFG_TOWER:     cfg_r.tower_num  <= cfg_wdata[TOWER_W-1:0];
        default:       cfg_r            <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s1_kind_r      <= in_kind;
      s1_back_r      <= in_back_sample;
      s1_front_r     <= in_front_sample;
      s1_spd_back_r  <= in_speed_back;
      s1_spd_front_r <= in_speed_front;
    end
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  sgds_ctrl #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (advance && s1_valid_r),
    .kind         (s1_kind_r),
    .back_sample  (s1_back_r),
    .front_sample (s1_front_r),
    .speed_back   (s1_spd_back_r),
    .speed_front  (s1_spd_front_r),
    .cfg          (cfg_r),
    .res_nxt      (res_nxt)
  );

  assign out_valid        = out_valid_r;
  assign out_back_drive   = res_r.back_drive;
  assign out_front_drive  = res_r.front_drive;
  assign out_tower_power  = res_r.tower_power;
  assign out_tower_select = res_r.tower_select;
  assign out_phase        = res_r.phase;
  assign out_done_res     = res_r.done_res;
  assign out_remaining    = res_r.remaining;

endmodule
